// ----- rtl/tct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection table package
// Shared widths, request codes, state codes and controller types.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int SLOTS_DEFAULT = 8;

  localparam int MODE_W   = 3;
  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int IDENT_W  = 16;
  localparam int SLOT_W   = 3;
  localparam int STATE_W  = 4;
  localparam int CURIN_W  = 5;
  localparam int CUROUT_W = 4;

  localparam logic [STATE_W-1:0] CONN_CLOSED = 4'd0;
  localparam logic [STATE_W-1:0] CONN_LISTEN = 4'd1;
  localparam logic [IDENT_W-1:0] IDENT_NONE  = 16'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 3'd0,
    MODE_SET    = 3'd1,
    MODE_FREE   = 3'd2,
    MODE_TUPLE  = 3'd3,
    MODE_LISTEN = 3'd4,
    MODE_IDENT  = 3'd5,
    MODE_ITER   = 3'd6
  } mode_t;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ----- rtl/tct_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection table controller
// Sequences one request: capture, then search and update, then the strobe.
// ----------------------------------------------------------------------------
module tct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output tct_pkg::cmd_t cmd
);

  tct_pkg::ctrl_state_t state;
  tct_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tct_pkg::CTRL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tct_pkg::CTRL_IDLE: begin
        if (start) state_next = tct_pkg::CTRL_EXEC;
      end
      tct_pkg::CTRL_EXEC: begin
        state_next = tct_pkg::CTRL_IDLE;
      end
      default: state_next = tct_pkg::CTRL_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    unique case (state)
      tct_pkg::CTRL_IDLE: begin
        cmd.load = start;
      end
      tct_pkg::CTRL_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy)
    else $error("Accepted request did not make the block busy.");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("Search cycle was not followed by a result strobe.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result strobe while busy.");
`endif

endmodule

// ----- rtl/tct_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection table datapath
// Slot registers, request capture, parallel compare, priority pick, update.
// ----------------------------------------------------------------------------
module tct_datapath #(
  parameter int SLOTS = tct_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tct_pkg::cmd_t                  cmd,
  input  logic [tct_pkg::MODE_W-1:0]     mode,
  input  logic [tct_pkg::IP_W-1:0]       remote_ip,
  input  logic [tct_pkg::PORT_W-1:0]     remote_port,
  input  logic [tct_pkg::PORT_W-1:0]     local_port,
  input  logic [tct_pkg::IDENT_W-1:0]    conn_ident,
  input  logic [tct_pkg::SLOT_W-1:0]     slot_index,
  input  logic [tct_pkg::STATE_W-1:0]    new_state,
  input  logic signed [tct_pkg::CURIN_W-1:0] start_after,
  output logic                           hit,
  output logic [tct_pkg::SLOT_W-1:0]     found_slot,
  output logic [tct_pkg::STATE_W-1:0]    found_state,
  output logic [tct_pkg::IDENT_W-1:0]    found_ident,
  output logic [tct_pkg::CUROUT_W-1:0]   next_cursor
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = ((IW > tct_pkg::CURIN_W) ? IW : tct_pkg::CURIN_W) + 1;

  logic [SLOTS-1:0]               used;
  logic [tct_pkg::STATE_W-1:0]    st    [SLOTS];
  logic [tct_pkg::IP_W-1:0]       rip   [SLOTS];
  logic [tct_pkg::PORT_W-1:0]     rport [SLOTS];
  logic [tct_pkg::PORT_W-1:0]     lport [SLOTS];
  logic [tct_pkg::IDENT_W-1:0]    ident [SLOTS];

  tct_pkg::mode_t                 req_mode;
  logic [tct_pkg::IP_W-1:0]       req_ip;
  logic [tct_pkg::PORT_W-1:0]     req_rport;
  logic [tct_pkg::PORT_W-1:0]     req_lport;
  logic [tct_pkg::IDENT_W-1:0]    req_ident;
  logic [tct_pkg::SLOT_W-1:0]     req_slot;
  logic [tct_pkg::STATE_W-1:0]    req_state;
  logic [tct_pkg::CURIN_W-1:0]    req_cursor;

  logic [CW-1:0]    iter_start;
  logic [SLOTS-1:0] cand;
  logic [IW-1:0]    pick;
  logic             pick_any;
  logic [CW-1:0]    pick_ext;
  logic [CW-1:0]    cursor_ext;
  logic [SLOTS-1:0] wr_set;
  logic [SLOTS-1:0] wr_clear;
  logic [SLOTS-1:0] wr_alloc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode   <= tct_pkg::mode_t'(mode);
      req_ip     <= remote_ip;
      req_rport  <= remote_port;
      req_lport  <= local_port;
      req_ident  <= conn_ident;
      req_slot   <= slot_index;
      req_state  <= new_state;
      req_cursor <= start_after;
    end
  end

  always_comb begin
    if (req_cursor[tct_pkg::CURIN_W-1]) begin
      iter_start = '0;
    end else begin
      iter_start = CW'(req_cursor) + CW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      case (req_mode)
        tct_pkg::MODE_ALLOC:  cand[i] = !used[i];
        tct_pkg::MODE_TUPLE:  cand[i] = used[i] && (st[i] != tct_pkg::CONN_LISTEN)
                                        && (rip[i] == req_ip) && (rport[i] == req_rport)
                                        && (lport[i] == req_lport);
        tct_pkg::MODE_LISTEN: cand[i] = used[i] && (st[i] == tct_pkg::CONN_LISTEN)
                                        && (lport[i] == req_lport);
        tct_pkg::MODE_IDENT:  cand[i] = used[i] && (req_ident != tct_pkg::IDENT_NONE)
                                        && (ident[i] == req_ident);
        tct_pkg::MODE_ITER:   cand[i] = used[i] && (CW'(i) >= iter_start);
        default:              cand[i] = 1'b0;
      endcase
    end
  end

  always_comb begin
    pick     = '0;
    pick_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick     = IW'(i);
        pick_any = 1'b1;
      end
    end
  end

  assign pick_ext   = CW'(pick);
  assign cursor_ext = pick_any ? pick_ext : CW'(SLOTS);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      wr_set[i]   = cmd.exec && (req_mode == tct_pkg::MODE_SET)
                    && (CW'(req_slot) == CW'(i));
      wr_clear[i] = cmd.exec && (req_mode == tct_pkg::MODE_FREE)
                    && (CW'(req_slot) == CW'(i));
      wr_alloc[i] = cmd.exec && (req_mode == tct_pkg::MODE_ALLOC) && pick_any
                    && (pick == IW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        st[i]    <= tct_pkg::CONN_CLOSED;
        rip[i]   <= '0;
        rport[i] <= '0;
        lport[i] <= '0;
        ident[i] <= '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (wr_set[i]) begin
          st[i]    <= req_state;
          rip[i]   <= req_ip;
          rport[i] <= req_rport;
          lport[i] <= req_lport;
          ident[i] <= req_ident;
        end else if (wr_clear[i] || wr_alloc[i]) begin
          used[i]  <= wr_alloc[i];
          st[i]    <= tct_pkg::CONN_CLOSED;
          rip[i]   <= '0;
          rport[i] <= '0;
          lport[i] <= '0;
          ident[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit         <= pick_any;
      found_slot  <= pick_any ? pick_ext[tct_pkg::SLOT_W-1:0] : '0;
      found_state <= (pick_any && (req_mode != tct_pkg::MODE_ALLOC)) ? st[pick] : '0;
      found_ident <= (pick_any && (req_mode != tct_pkg::MODE_ALLOC)) ? ident[pick] : '0;
      next_cursor <= (req_mode == tct_pkg::MODE_ITER)
                     ? cursor_ext[tct_pkg::CUROUT_W-1:0] : '0;
    end
  end

endmodule

// ----- rtl/tcp_connection_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection table core
// Slot table with allocate, write, free, lookups and iteration.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low;
// its fields (mode, tuple, id, slot_index, new_state, start_after) are
// captured in that beat. The following cycle compares every slot in
// parallel, picks the lowest matching slot and applies any table update.
// In the cycle after that, done is high for exactly one cycle with hit,
// found_slot, found_state, found_ident and next_cursor valid; the result
// ports hold their value until the next result is presented.
// A new request may be accepted in the cycle that shows done, but not
// while the previous request is still being searched. This pace is set
// by the registered compare and update of the slot array. The receiver
// cannot stall results: done is a one-cycle strobe and must be sampled
// when it is high.
// Synchronous reset clears every slot to unused and closed with all fields
// zero, returns the controller to idle and drops done; requests may be
// issued in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module tcp_connection_table_core #(
  parameter int SLOTS = tct_pkg::SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [tct_pkg::MODE_W-1:0]         mode,
  input  logic [tct_pkg::IP_W-1:0]           remote_ip,
  input  logic [tct_pkg::PORT_W-1:0]         remote_port,
  input  logic [tct_pkg::PORT_W-1:0]         local_port,
  input  logic [tct_pkg::IDENT_W-1:0]        conn_ident,
  input  logic [tct_pkg::SLOT_W-1:0]         slot_index,
  input  logic [tct_pkg::STATE_W-1:0]        new_state,
  input  logic signed [tct_pkg::CURIN_W-1:0] start_after,
  output logic                               done,
  output logic                               hit,
  output logic [tct_pkg::SLOT_W-1:0]         found_slot,
  output logic [tct_pkg::STATE_W-1:0]        found_state,
  output logic [tct_pkg::IDENT_W-1:0]        found_ident,
  output logic [tct_pkg::CUROUT_W-1:0]       next_cursor
);

  tct_pkg::cmd_t cmd;

  tct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tct_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .remote_ip   (remote_ip),
    .remote_port (remote_port),
    .local_port  (local_port),
    .conn_ident  (conn_ident),
    .slot_index  (slot_index),
    .new_state   (new_state),
    .start_after (start_after),
    .hit         (hit),
    .found_slot  (found_slot),
    .found_state (found_state),
    .found_ident (found_ident),
    .next_cursor (next_cursor)
  );

endmodule

// ----- verif/tct_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection table checker
// Watches the request and result ports of the connection table core, keeps
// its own copy of the slot table, works out the result of every accepted
// request and compares each result beat field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tct_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [tct_pkg::MODE_W-1:0]         mode,
  input  logic [tct_pkg::IP_W-1:0]           remote_ip,
  input  logic [tct_pkg::PORT_W-1:0]         remote_port,
  input  logic [tct_pkg::PORT_W-1:0]         local_port,
  input  logic [tct_pkg::IDENT_W-1:0]        conn_ident,
  input  logic [tct_pkg::SLOT_W-1:0]         slot_index,
  input  logic [tct_pkg::STATE_W-1:0]        new_state,
  input  logic signed [tct_pkg::CURIN_W-1:0] start_after,
  input  logic                               done,
  input  logic                               hit,
  input  logic [tct_pkg::SLOT_W-1:0]         found_slot,
  input  logic [tct_pkg::STATE_W-1:0]        found_state,
  input  logic [tct_pkg::IDENT_W-1:0]        found_ident,
  input  logic [tct_pkg::CUROUT_W-1:0]       next_cursor,
  output int                                 mismatches,
  output int                                 outstanding
);

  import tct_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEFAULT;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [STATE_W-1:0]  state;
    logic [IDENT_W-1:0]  ident;
    logic [CUROUT_W-1:0] cursor;
  } lookup_result_t;

  logic                tbl_used        [NUM_SLOTS];
  logic [STATE_W-1:0]  tbl_state       [NUM_SLOTS];
  logic [IP_W-1:0]     tbl_remote_ip   [NUM_SLOTS];
  logic [PORT_W-1:0]   tbl_remote_port [NUM_SLOTS];
  logic [PORT_W-1:0]   tbl_local_port  [NUM_SLOTS];
  logic [IDENT_W-1:0]  tbl_ident       [NUM_SLOTS];

  lookup_result_t expected_lookups[$];
  lookup_result_t want;

  function automatic void clear_entry(input int i);
    tbl_used[i]        = 1'b0;
    tbl_state[i]       = CONN_CLOSED;
    tbl_remote_ip[i]   = '0;
    tbl_remote_port[i] = '0;
    tbl_local_port[i]  = '0;
    tbl_ident[i]       = IDENT_NONE;
  endfunction

  function automatic lookup_result_t slot_report(input int i);
    lookup_result_t res;
    res        = '0;
    res.hit    = 1'b1;
    res.slot   = SLOT_W'(i);
    res.state  = tbl_state[i];
    res.ident  = tbl_ident[i];
    return res;
  endfunction

  // Applies one request to the shadow table and returns the result it gives.
  function automatic lookup_result_t apply_request(
    input logic [MODE_W-1:0]         req_mode,
    input logic [IP_W-1:0]           ip,
    input logic [PORT_W-1:0]         rport,
    input logic [PORT_W-1:0]         lport,
    input logic [IDENT_W-1:0]        id,
    input logic [SLOT_W-1:0]         idx,
    input logic [STATE_W-1:0]        st,
    input logic signed [CURIN_W-1:0] cursor_in
  );
    lookup_result_t res;
    logic           found;
    int             first;
    res   = '0;
    found = 1'b0;
    first = 0;
    case (req_mode)
      MODE_ALLOC: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !tbl_used[i]) begin
            found = 1'b1;
            clear_entry(i);
            tbl_used[i]  = 1'b1;
            tbl_state[i] = CONN_CLOSED;
            res = slot_report(i);
          end
        end
      end
      MODE_SET: begin
        if (int'(idx) < NUM_SLOTS) begin
          tbl_state[idx]       = st;
          tbl_remote_ip[idx]   = ip;
          tbl_remote_port[idx] = rport;
          tbl_local_port[idx]  = lport;
          tbl_ident[idx]       = id;
        end
      end
      MODE_FREE: begin
        if (int'(idx) < NUM_SLOTS) clear_entry(int'(idx));
      end
      MODE_TUPLE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && tbl_used[i] && tbl_state[i] != CONN_LISTEN &&
              tbl_remote_ip[i] == ip && tbl_remote_port[i] == rport &&
              tbl_local_port[i] == lport) begin
            found = 1'b1;
            res = slot_report(i);
          end
        end
      end
      MODE_LISTEN: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && tbl_used[i] && tbl_state[i] == CONN_LISTEN &&
              tbl_local_port[i] == lport) begin
            found = 1'b1;
            res = slot_report(i);
          end
        end
      end
      MODE_IDENT: begin
        if (id != IDENT_NONE) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && tbl_used[i] && tbl_ident[i] == id) begin
              found = 1'b1;
              res = slot_report(i);
            end
          end
        end
      end
      MODE_ITER: begin
        // A negative cursor restarts the walk at slot zero.
        first = cursor_in[CURIN_W-1] ? 0 : int'(cursor_in[CURIN_W-2:0]) + 1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && i >= first && tbl_used[i]) begin
            found = 1'b1;
            res = slot_report(i);
            res.cursor = CUROUT_W'(i);
          end
        end
        if (!found) res.cursor = CUROUT_W'(NUM_SLOTS);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) clear_entry(i);
      expected_lookups.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", 32'(found_slot), 0);
        end else begin
          want = expected_lookups.pop_front();
          if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
          if (found_slot !== want.slot)
            report_mismatch("found_slot", 32'(found_slot), 32'(want.slot));
          if (found_state !== want.state)
            report_mismatch("found_state", 32'(found_state), 32'(want.state));
          if (found_ident !== want.ident)
            report_mismatch("found_ident", 32'(found_ident), 32'(want.ident));
          if (next_cursor !== want.cursor)
            report_mismatch("next_cursor", 32'(next_cursor), 32'(want.cursor));
        end
      end
      if (start && !busy) begin
        expected_lookups.push_back(apply_request(mode, remote_ip, remote_port, local_port,
                                                 conn_ident, slot_index, new_state,
                                                 start_after));
      end
    end
    outstanding <= expected_lookups.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection table testbench
// Drives directed and random requests into the connection table core with
// random gaps between beats, drains the table between phases and reports
// the verdict from the mismatch and outstanding counts of the checker.
// ----------------------------------------------------------------------------
module tb;

  import tct_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [MODE_W-1:0]           mode;
  logic [IP_W-1:0]             remote_ip;
  logic [PORT_W-1:0]           remote_port;
  logic [PORT_W-1:0]           local_port;
  logic [IDENT_W-1:0]          conn_ident;
  logic [SLOT_W-1:0]           slot_index;
  logic [STATE_W-1:0]          new_state;
  logic signed [CURIN_W-1:0]   start_after;
  logic                        done;
  logic                        hit;
  logic [SLOT_W-1:0]           found_slot;
  logic [STATE_W-1:0]          found_state;
  logic [IDENT_W-1:0]          found_ident;
  logic [CUROUT_W-1:0]         next_cursor;
  int                          mismatches;
  int                          outstanding;
  int                          cycles = 0;
  int                          idle_style;

  tcp_connection_table_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .remote_ip   (remote_ip),
    .remote_port (remote_port),
    .local_port  (local_port),
    .conn_ident  (conn_ident),
    .slot_index  (slot_index),
    .new_state   (new_state),
    .start_after (start_after),
    .done        (done),
    .hit         (hit),
    .found_slot  (found_slot),
    .found_state (found_state),
    .found_ident (found_ident),
    .next_cursor (next_cursor)
  );

  tct_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .remote_ip   (remote_ip),
    .remote_port (remote_port),
    .local_port  (local_port),
    .conn_ident  (conn_ident),
    .slot_index  (slot_index),
    .new_state   (new_state),
    .start_after (start_after),
    .done        (done),
    .hit         (hit),
    .found_slot  (found_slot),
    .found_state (found_state),
    .found_ident (found_ident),
    .next_cursor (next_cursor),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Presents one request beat after an optional idle gap and holds it until accepted.
  task automatic issue(input logic [MODE_W-1:0] m, input logic [IP_W-1:0] ip,
                       input logic [PORT_W-1:0] rport, input logic [PORT_W-1:0] lport,
                       input logic [IDENT_W-1:0] id, input logic [SLOT_W-1:0] idx,
                       input logic [STATE_W-1:0] st, input logic [CURIN_W-1:0] cur);
    int gap;
    case (idle_style)
      0:       gap = 0;
      1:       gap = $urandom_range(0, 15);
      default: gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
    endcase
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode        <= m;
    remote_ip   <= ip;
    remote_port <= rport;
    local_port  <= lport;
    conn_ident  <= id;
    slot_index  <= idx;
    new_state   <= st;
    start_after <= cur;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Tuples and ids come mostly from small sets so that lookups hit often.
  task automatic random_request();
    int                  pick;
    logic [MODE_W-1:0]   m;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   rport;
    logic [PORT_W-1:0]   lport;
    logic [IDENT_W-1:0]  id;
    logic [STATE_W-1:0]  st;
    logic [CURIN_W-1:0]  cur;
    pick = $urandom_range(0, 99);
    if      (pick < 15) m = MODE_ALLOC;
    else if (pick < 35) m = MODE_SET;
    else if (pick < 45) m = MODE_FREE;
    else if (pick < 60) m = MODE_TUPLE;
    else if (pick < 72) m = MODE_LISTEN;
    else if (pick < 84) m = MODE_IDENT;
    else if (pick < 98) m = MODE_ITER;
    else                m = MODE_UNUSED;
    ip    = ($urandom_range(0, 4) == 0) ? $urandom : 32'hc0a8_0000 + $urandom_range(0, 2);
    rport = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'd1024 + 16'($urandom_range(0, 2));
    lport = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'd80 + 16'($urandom_range(0, 2));
    id    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    st    = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    cur   = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'(int'($urandom_range(0, 9)) - 1);
    issue(m, ip, rport, lport, id, 3'($urandom), st, cur);
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    mode        = MODE_ALLOC;
    remote_ip   = '0;
    remote_port = '0;
    local_port  = '0;
    conn_ident  = '0;
    slot_index  = '0;
    new_state   = CONN_CLOSED;
    start_after = '0;
    idle_style  = 2;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(MODE_ITER, '0, '0, '0, '0, '0, CONN_CLOSED, -5'sd1);
    repeat (9) issue(MODE_ALLOC, '0, '0, '0, '0, '0, CONN_CLOSED, '0);
    issue(MODE_SET, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 3'd0, 4'hf, '0);
    issue(MODE_SET, 32'h0a00_0001, 16'd0, 16'd80, IDENT_NONE, 3'd1, CONN_LISTEN, '0);
    issue(MODE_SET, '0, '0, '0, 16'd1, 3'd7, 4'd10, '0);
    issue(MODE_TUPLE, 32'hffff_ffff, 16'hffff, 16'hffff, '0, '0, CONN_CLOSED, '0);
    issue(MODE_TUPLE, 32'h0a00_0001, 16'd0, 16'd80, '0, '0, CONN_CLOSED, '0);
    issue(MODE_LISTEN, '0, '0, 16'd80, '0, '0, CONN_CLOSED, '0);
    issue(MODE_LISTEN, '0, '0, 16'd81, '0, '0, CONN_CLOSED, '0);
    issue(MODE_IDENT, '0, '0, '0, IDENT_NONE, '0, CONN_CLOSED, '0);
    issue(MODE_IDENT, '0, '0, '0, 16'hffff, '0, CONN_CLOSED, '0);
    issue(MODE_FREE, '0, '0, '0, '0, 3'd3, CONN_CLOSED, '0);
    issue(MODE_ITER, '0, '0, '0, '0, '0, CONN_CLOSED, 5'sd2);
    issue(MODE_ITER, '0, '0, '0, '0, '0, CONN_CLOSED, 5'sd7);
    issue(MODE_ITER, '0, '0, '0, '0, '0, CONN_CLOSED, 5'sd15);
    issue(MODE_ITER, '0, '0, '0, '0, '0, CONN_CLOSED, -5'sd16);
    issue(MODE_ALLOC, '0, '0, '0, '0, '0, CONN_CLOSED, '0);
    issue(MODE_UNUSED, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 3'd7, 4'hf, 5'h1f);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      idle_style = phase % 3;
      repeat (130) random_request();
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
